FILE: hdl/tpcs_pkg.sv
package tpcs_pkg;

    localparam int unsigned PAGE_BYTES_DEFAULT = 128;

    localparam int unsigned LEN_W       = 16;
    localparam int unsigned DEFICIT_W   = 12;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned CREDIT_W    = 32;
    localparam int unsigned PAGES_OUT_W = 10;
    localparam int unsigned REFILL_W    = HALF_W + 2;
    localparam int unsigned CFG_INDEX_W = 1;

    // Frame length plus deficit plus rounding term stays below 2**17.
    localparam int unsigned SUM_W = LEN_W + 1;

    localparam logic [CREDIT_W-1:0] PAGES_FIELD_MAX = CREDIT_W'(1023);

    typedef enum logic
    {
        ACT_SEND   = 1'b0,
        ACT_REFILL = 1'b1
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_DEFICIT     = 1'b0,
        CFG_MCU_RUNNING = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        action_t             action;
        logic [LEN_W-1:0]    frame_len;
        logic                is_mcu;
        logic                is_control;
        logic [WORD_W-1:0]   status_word0;
        logic [WORD_W-1:0]   status_word1;
        logic [WORD_W-1:0]   status_word2;
        logic [WORD_W-1:0]   status_word3;
        logic [WORD_W-1:0]   status_word4;
    } tx_item_t;

    typedef struct packed
    {
        logic                   granted;
        logic [PAGES_OUT_W-1:0] pages_needed;
        logic [CREDIT_W-1:0]    data_pages_left;
        logic [CREDIT_W-1:0]    data_packets_left;
        logic [CREDIT_W-1:0]    mcu_pages_left;
    } tx_result_t;

    typedef struct packed
    {
        logic                 write;
        cfg_index_t           index;
        logic [DEFICIT_W-1:0] data;
    } cfg_write_t;

    function automatic logic [CREDIT_W-1:0] sat_add(
        input logic [CREDIT_W-1:0] a,
        input logic [REFILL_W-1:0] b
    );
        logic [CREDIT_W:0] s;
        s = {1'b0, a} + (CREDIT_W + 1)'(b);
        return s[CREDIT_W] ? '1 : s[CREDIT_W-1:0];
    endfunction

endpackage

FILE: hdl/tpcs_in_stage.sv
module tpcs_in_stage
    import tpcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  tx_item_t item_in,
    input  logic     advance,
    output logic     item_valid,
    output tx_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    tx_item_t item_reg;
    logic     accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

endmodule

FILE: hdl/tpcs_credit_core.sv
module tpcs_credit_core
    import tpcs_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  tx_item_t   item,
    input  logic       advance,
    output tx_result_t result
);

    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned PAGES_W    = SUM_W - PAGE_SHIFT;

    logic [DEFICIT_W-1:0] deficit_reg;
    logic [DEFICIT_W-1:0] deficit_next;
    logic                 mcu_running_reg;
    logic                 mcu_running_next;
    logic [CREDIT_W-1:0]  data_page_credit_reg;
    logic [CREDIT_W-1:0]  data_page_credit_next;
    logic [CREDIT_W-1:0]  data_packet_credit_reg;
    logic [CREDIT_W-1:0]  data_packet_credit_next;
    logic [CREDIT_W-1:0]  mcu_page_credit_reg;
    logic [CREDIT_W-1:0]  mcu_page_credit_next;

    logic [SUM_W-1:0]     total;
    logic [PAGES_W-1:0]   pages;
    logic [CREDIT_W-1:0]  pages_ext;
    logic [REFILL_W-1:0]  add_pages;
    logic [REFILL_W-1:0]  add_pkts;
    logic                 granted;

    assign total = SUM_W'(item.frame_len) + SUM_W'(deficit_reg) + SUM_W'(PAGE_BYTES - 1);
    assign pages     = total[SUM_W-1:PAGE_SHIFT];
    assign pages_ext = CREDIT_W'(pages);

    assign add_pages = REFILL_W'(item.status_word0[HALF_W-1:0])
                     + REFILL_W'(item.status_word0[WORD_W-1:HALF_W])
                     + REFILL_W'(item.status_word1[HALF_W-1:0])
                     + REFILL_W'(item.status_word1[WORD_W-1:HALF_W]);
    assign add_pkts  = REFILL_W'(item.status_word2[WORD_W-1:HALF_W])
                     + REFILL_W'(item.status_word3[HALF_W-1:0])
                     + REFILL_W'(item.status_word3[WORD_W-1:HALF_W])
                     + REFILL_W'(item.status_word4[HALF_W-1:0]);

    always_comb
    begin
        deficit_next     = deficit_reg;
        mcu_running_next = mcu_running_reg;
        if (cfg.write)
        begin
            unique case (cfg.index)
                CFG_DEFICIT:
                begin
                    deficit_next = cfg.data;
                end
                CFG_MCU_RUNNING:
                begin
                    mcu_running_next = cfg.data[0];
                end
                default:
                begin
                    deficit_next = deficit_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        granted                 = 1'b1;
        data_page_credit_next   = data_page_credit_reg;
        data_packet_credit_next = data_packet_credit_reg;
        mcu_page_credit_next    = mcu_page_credit_reg;
        result.pages_needed     = '0;

        unique case (item.action)
            ACT_SEND:
            begin
                result.pages_needed = (pages_ext > PAGES_FIELD_MAX)
                                    ? '1 : PAGES_OUT_W'(pages_ext);
                if (item.is_mcu)
                begin
                    if (mcu_running_reg)
                    begin
                        if (mcu_page_credit_reg > pages_ext)
                        begin
                            mcu_page_credit_next = mcu_page_credit_reg - pages_ext;
                        end
                        else
                        begin
                            granted = 1'b0;
                        end
                    end
                end
                else if (!item.is_control)
                begin
                    if ((data_page_credit_reg > pages_ext) && (data_packet_credit_reg != '0))
                    begin
                        data_page_credit_next   = data_page_credit_reg - pages_ext;
                        data_packet_credit_next = data_packet_credit_reg - CREDIT_W'(1);
                    end
                    else
                    begin
                        granted = 1'b0;
                    end
                end
            end
            ACT_REFILL:
            begin
                data_page_credit_next   = sat_add(data_page_credit_reg, add_pages);
                data_packet_credit_next = sat_add(data_packet_credit_reg, add_pkts);
                mcu_page_credit_next    = sat_add(mcu_page_credit_reg,
                                              REFILL_W'(item.status_word2[HALF_W-1:0]));
            end
            default:
            begin
                granted = 1'b1;
            end
        endcase

        result.granted           = granted;
        result.data_pages_left   = data_page_credit_next;
        result.data_packets_left = data_packet_credit_next;
        result.mcu_pages_left    = mcu_page_credit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deficit_reg            <= '0;
            mcu_running_reg        <= 1'b0;
            data_page_credit_reg   <= '0;
            data_packet_credit_reg <= '0;
            mcu_page_credit_reg    <= '0;
        end
        else
        begin
            deficit_reg     <= deficit_next;
            mcu_running_reg <= mcu_running_next;
            if (advance)
            begin
                data_page_credit_reg   <= data_page_credit_next;
                data_packet_credit_reg <= data_packet_credit_next;
                mcu_page_credit_reg    <= mcu_page_credit_next;
            end
        end
    end

endmodule

FILE: hdl/tx_page_credit_scheduler.sv
// Items pass the input stage register, then the result register. Throughput:
// one item per cycle while the output is not stalled; the credit counters are
// updated in the same cycle as the result register is loaded, so each item sees
// the previous one. Reset (rst_n low, asynchronous) clears both stage valids,
// all three credit counters and the deficit and processor-running registers.
module tx_page_credit_scheduler
    import tpcs_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [LEN_W-1:0]       frame_len,
    input  logic                   is_mcu,
    input  logic                   is_control,
    input  logic [WORD_W-1:0]      status_word0,
    input  logic [WORD_W-1:0]      status_word1,
    input  logic [WORD_W-1:0]      status_word2,
    input  logic [WORD_W-1:0]      status_word3,
    input  logic [WORD_W-1:0]      status_word4,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   granted,
    output logic [PAGES_OUT_W-1:0] pages_needed,
    output logic [CREDIT_W-1:0]    data_pages_left,
    output logic [CREDIT_W-1:0]    data_packets_left,
    output logic [CREDIT_W-1:0]    mcu_pages_left,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DEFICIT_W-1:0]   cfg_data
);

    tx_item_t   item_in;
    tx_item_t   item;
    logic       item_valid;
    logic       advance;
    cfg_write_t cfg;
    tx_result_t result;
    tx_result_t result_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign item_in.action       = action_t'(action);
    assign item_in.frame_len    = frame_len;
    assign item_in.is_mcu       = is_mcu;
    assign item_in.is_control   = is_control;
    assign item_in.status_word0 = status_word0;
    assign item_in.status_word1 = status_word1;
    assign item_in.status_word2 = status_word2;
    assign item_in.status_word3 = status_word3;
    assign item_in.status_word4 = status_word4;

    assign cfg_ready = 1'b1;
    assign cfg.write = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index_t'(cfg_index);
    assign cfg.data  = cfg_data;

    assign advance = item_valid && (!out_valid_reg || !out_stall);

    tpcs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tpcs_credit_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_credit_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign granted           = result_reg.granted;
    assign pages_needed      = result_reg.pages_needed;
    assign data_pages_left   = result_reg.data_pages_left;
    assign data_packets_left = result_reg.data_packets_left;
    assign mcu_pages_left    = result_reg.mcu_pages_left;

endmodule

FILE: hdl/tpcs_checker.sv
module tpcs_checker
    import tpcs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   granted,
    input logic [PAGES_OUT_W-1:0] pages_needed,
    input logic [CREDIT_W-1:0]    data_pages_left,
    input logic [CREDIT_W-1:0]    data_packets_left,
    input logic [CREDIT_W-1:0]    mcu_pages_left
);

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Result offered during reset.");

    // Input is held back only when a finished result is itself held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("Input stalled while the output side could move.");

    // Every input transfer is followed by a result on offer at the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 out_valid)
        else $error("No result two cycles after an input transfer.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(granted)
            && $stable(pages_needed) && $stable(data_pages_left)
            && $stable(data_packets_left) && $stable(mcu_pages_left)))
        else $error("Stalled result changed.");

endmodule

bind tx_page_credit_scheduler tpcs_checker u_tpcs_checker (.*);
